>>> design/cpq_pkg.sv
// Types and constants shared by the class priority queue.
package cpq_pkg;

  localparam int TAG_FIELD_W = 16;
  localparam int CLASS_W     = 3;

  typedef enum logic [1:0] {
    CMD_ADD       = 2'd0,
    CMD_SERVE_ONE = 2'd1,
    CMD_SERVE_ALL = 2'd2,
    CMD_DISMISS   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SERVED    = 3'd0,
    ST_ADDED     = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_DISMISSED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_TOP     = 2'd0,
    KIND_HIGH    = 2'd1,
    KIND_REGULAR = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  localparam logic [CLASS_W-1:0] CLASS_TOP     = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_HIGH    = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_MEMBER  = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_GUEST   = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd4;

  typedef struct packed {
    cmd_t                   command;
    logic [TAG_FIELD_W-1:0] request_tag;
    logic [CLASS_W-1:0]     class_code;
  } req_t;

  typedef struct packed {
    logic [TAG_FIELD_W-1:0] served_tag;
    logic [CLASS_W-1:0]     served_class;
    kind_t                  service_kind;
    status_t                status;
    logic                   last_of_run;
  } rsp_t;

  function automatic kind_t kind_of(input logic [CLASS_W-1:0] cls);
    kind_t k;
    case (cls)
      CLASS_TOP:                 k = KIND_TOP;
      CLASS_HIGH:                k = KIND_HIGH;
      CLASS_MEMBER, CLASS_GUEST: k = KIND_REGULAR;
      default:                   k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

>>> design/class_priority_queue_top.sv
// Class priority queue: sorted insert into a circular buffer held in one memory.
//
//  channel | signals                       | payload | direction
//  req     | req_valid, req_stall, req_data | req_t   | command in
//  rsp     | rsp_valid, rsp_stall, rsp_data | rsp_t   | result out
//
// One command is handled at a time; req_stall is high until its last result is
// loaded into the output register. Add moves each entry of a worse class up
// one place (one memory read then one write each) until it meets an equal or
// better class or reaches the head. Serve-all reads each entry from the entry
// memory and then loads it into the output register, one entry at a time.
// Reset empties the queue at once; entry contents are not cleared.
// A stalled result holds in the output register, and the block waits for it.
module class_priority_queue_top
  import cpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = CLASS_W + TAG_BITS;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS_RD   = 7'b0000010,
    S_INS_CMP  = 7'b0000100,
    S_POP_LD   = 7'b0001000,
    S_DRAIN_RD = 7'b0010000,
    S_DRAIN_LD = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   pos;
  logic [TAG_BITS-1:0] tag_r;
  logic [CLASS_W-1:0] cls_r;
  status_t            resp_status;

  logic [ENT_W-1:0]   mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]   rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;

  logic [TAG_BITS+TAG_FIELD_W-1:0] tag_in_ext;
  logic [TAG_BITS-1:0]             tag_in;
  logic [CLASS_W-1:0]              cls_in;
  logic [TAG_FIELD_W+TAG_BITS-1:0] tag_out_ext;
  logic [TAG_FIELD_W-1:0]          tag_out;
  logic [CLASS_W-1:0]              rd_class;
  logic                            move_up;
  logic                            rsp_free;
  logic                            rsp_load;
  logic                            full;
  logic                            last_entry;

  // Map a queue position to a memory address, wrapping past the end.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] p);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, p};
    if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  assign tag_in_ext  = {{TAG_BITS{1'b0}}, req_data.request_tag};
  assign tag_in      = tag_in_ext[TAG_BITS-1:0];
  assign cls_in      = (req_data.class_code > CLASS_UNKNOWN) ? CLASS_UNKNOWN
                                                             : req_data.class_code;
  assign rd_class    = rd_data[ENT_W-1 -: CLASS_W];
  assign tag_out_ext = {{TAG_FIELD_W{1'b0}}, rd_data[TAG_BITS-1:0]};
  assign tag_out     = tag_out_ext[TAG_FIELD_W-1:0];
  assign move_up     = rd_class > cls_r;
  assign rsp_free    = !rsp_valid || !rsp_stall;
  assign rsp_load    = rsp_free && (state inside {S_POP_LD, S_DRAIN_LD, S_RESP});
  assign full        = count == CNT_W'(QUEUE_DEPTH);
  assign last_entry  = (CNT_W'(pos) + CNT_W'(1)) == count;
  assign req_stall   = state != S_IDLE;

  // Memory port control. A step never reads the address written in the same
  // or the previous cycle, so no forwarding is needed.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = phys(head, pos);
    wr_data = {cls_r, tag_r};
    case (state)
      S_IDLE: begin
        if (req_valid && req_data.command == CMD_SERVE_ONE && count != '0) begin
          rd_en = 1'b1;
        end
      end
      S_INS_RD: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys(head, pos - IDX_W'(1));
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (move_up) wr_data = rd_data;
      end
      S_DRAIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(head, pos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Output valid: set on a load, drop once the transfer happens.
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (rsp_load) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      pos       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            tag_r <= tag_in;
            cls_r <= cls_in;
            case (req_data.command)
              CMD_ADD: begin
                if (full) begin
                  resp_status <= ST_FULL;
                  state       <= S_RESP;
                end else begin
                  pos   <= count[IDX_W-1:0];
                  state <= S_INS_RD;
                end
              end
              CMD_SERVE_ONE: begin
                if (count == '0) begin
                  resp_status <= ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  state <= S_POP_LD;
                end
              end
              CMD_SERVE_ALL: begin
                if (count == '0) begin
                  resp_status <= ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  pos   <= '0;
                  state <= S_DRAIN_RD;
                end
              end
              default: begin
                count       <= '0;
                resp_status <= ST_DISMISSED;
                state       <= S_RESP;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            count       <= count + CNT_W'(1);
            resp_status <= ST_ADDED;
            state       <= S_RESP;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (move_up) begin
            // Entry moved up one place; keep walking toward the head.
            pos   <= pos - IDX_W'(1);
            state <= S_INS_RD;
          end else begin
            count       <= count + CNT_W'(1);
            resp_status <= ST_ADDED;
            state       <= S_RESP;
          end
        end
        S_POP_LD: begin
          if (rsp_free) begin
            rsp_data.served_tag   <= tag_out;
            rsp_data.served_class <= rd_class;
            rsp_data.service_kind <= kind_of(rd_class);
            rsp_data.status       <= ST_SERVED;
            rsp_data.last_of_run  <= 1'b1;
            head                  <= phys(head, IDX_W'(1));
            count                 <= count - CNT_W'(1);
            state                 <= S_IDLE;
          end
        end
        S_DRAIN_RD: begin
          state <= S_DRAIN_LD;
        end
        S_DRAIN_LD: begin
          if (rsp_free) begin
            rsp_data.served_tag   <= tag_out;
            rsp_data.served_class <= rd_class;
            rsp_data.service_kind <= kind_of(rd_class);
            rsp_data.status       <= ST_SERVED;
            rsp_data.last_of_run  <= last_entry;
            if (last_entry) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              pos   <= pos + IDX_W'(1);
              state <= S_DRAIN_RD;
            end
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp_data.served_tag   <= '0;
            rsp_data.served_class <= '0;
            rsp_data.service_kind <= KIND_NONE;
            rsp_data.status       <= resp_status;
            rsp_data.last_of_run  <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_cmp_not_head: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_CMP |-> pos != '0)
    else $error("insert compare at the head position");

  a_drain_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN_LD |-> CNT_W'(pos) < count)
    else $error("serve-all index past the last entry");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_LD |-> count != '0)
    else $error("pop from an empty queue");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_RD && pos == '0 |=> count == $past(count) + CNT_W'(1))
    else $error("add at head did not grow the queue");

endmodule

>>> verif/tb_class_priority_queue_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for class_priority_queue_top: directed table plus random commands.
module tb_class_priority_queue_top;
  import cpq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 75;
  localparam int NUM_STEPS    = 25;

  typedef struct packed {
    cmd_t               command;
    logic [15:0]        tag;
    logic [CLASS_W-1:0] cls;
    logic               typed;
    status_t            want;
  } step_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_data;

  // shadow of the queue contents, kept in class order
  logic [15:0]        shadow_tags    [QUEUE_DEPTH];
  logic [CLASS_W-1:0] shadow_classes [QUEUE_DEPTH];
  int                 entry_total;

  rsp_t  awaited_results [$];
  rsp_t  oldest;
  step_t directed_steps [NUM_STEPS];

  int errors;
  int results_seen;
  int commands_sent;
  int full_hits;
  int drain_runs;
  int idle_cycles;
  int hold_left;
  bit held_once;
  bit sender_gaps;

  class_priority_queue_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (16)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always #6 clk = ~clk;

  function automatic rsp_t status_only(input status_t s);
    rsp_t r;
    r = '0;
    r.service_kind = KIND_NONE;
    r.status       = s;
    r.last_of_run  = 1'b1;
    return r;
  endfunction

  function automatic rsp_t entry_result(input int pos, input bit last);
    rsp_t r;
    r.served_tag   = shadow_tags[pos];
    r.served_class = shadow_classes[pos];
    case (shadow_classes[pos])
      CLASS_TOP:                 r.service_kind = KIND_TOP;
      CLASS_HIGH:                r.service_kind = KIND_HIGH;
      CLASS_MEMBER, CLASS_GUEST: r.service_kind = KIND_REGULAR;
      default:                   r.service_kind = KIND_NONE;
    endcase
    r.status      = ST_SERVED;
    r.last_of_run = last;
    return r;
  endfunction

  // Update the shadow queue for one command and queue the results it causes.
  function automatic void apply_command(input req_t r);
    logic [CLASS_W-1:0] cls;
    int pos;
    cls = (r.class_code > CLASS_UNKNOWN) ? CLASS_UNKNOWN : r.class_code;
    case (r.command)
      CMD_ADD: begin
        if (entry_total >= QUEUE_DEPTH) begin
          awaited_results.push_back(status_only(ST_FULL));
          full_hits++;
        end else begin
          // shift worse classes up, stop behind equal or better ones
          pos = entry_total;
          while (pos > 0 && shadow_classes[pos-1] > cls) begin
            shadow_tags[pos]    = shadow_tags[pos-1];
            shadow_classes[pos] = shadow_classes[pos-1];
            pos--;
          end
          shadow_tags[pos]    = r.request_tag;
          shadow_classes[pos] = cls;
          entry_total++;
          awaited_results.push_back(status_only(ST_ADDED));
        end
      end
      CMD_SERVE_ONE: begin
        if (entry_total == 0) begin
          awaited_results.push_back(status_only(ST_EMPTY));
        end else begin
          awaited_results.push_back(entry_result(0, 1'b1));
          for (pos = 1; pos < entry_total; pos++) begin
            shadow_tags[pos-1]    = shadow_tags[pos];
            shadow_classes[pos-1] = shadow_classes[pos];
          end
          entry_total--;
        end
      end
      CMD_SERVE_ALL: begin
        if (entry_total == 0) begin
          awaited_results.push_back(status_only(ST_EMPTY));
        end else begin
          for (pos = 0; pos < entry_total; pos++)
            awaited_results.push_back(entry_result(pos, pos == entry_total - 1));
          entry_total = 0;
          drain_runs++;
        end
      end
      CMD_DISMISS: begin
        entry_total = 0;
        awaited_results.push_back(status_only(ST_DISMISSED));
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offer one command and hold it until the transfer happens.
  task automatic send_command(input req_t r, input bit typed, input status_t want);
    @(negedge clk);
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_command(r);
    if (typed) begin
      void'(awaited_results.pop_back());
      awaited_results.push_back(status_only(want));
    end
    commands_sent++;
    if (sender_gaps && $urandom_range(99) < 7) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, rsp_data);
        errors++;
      end else begin
        oldest = awaited_results.pop_front();
        compare_field("served_tag", 32'(oldest.served_tag), 32'(rsp_data.served_tag));
        compare_field("served_class", 32'(oldest.served_class),
                      32'(rsp_data.served_class));
        compare_field("service_kind", 32'(oldest.service_kind),
                      32'(rsp_data.service_kind));
        compare_field("status", 32'(oldest.status), 32'(rsp_data.status));
        compare_field("last_of_run", 32'(oldest.last_of_run), 32'(rsp_data.last_of_run));
      end
      results_seen++;
    end
  end

  // Receiver: random stalls, one long hold-off, and a clean stretch
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held_once && results_seen >= 70) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (results_seen >= 100 && results_seen < 140) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < 7);
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("class_priority_queue_top verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    req_t r;
    int   pick;
    int   add_share;
    clk          = 1'b0;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req_data     = '0;
    rsp_stall    = 1'b0;
    entry_total  = 0;
    errors       = 0;
    results_seen = 0;
    commands_sent = 0;
    full_hits    = 0;
    drain_runs   = 0;
    idle_cycles  = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    sender_gaps  = 1'b1;

    directed_steps = '{
      '{CMD_SERVE_ONE, 16'h0000, CLASS_TOP,     1'b1, ST_EMPTY},
      '{CMD_SERVE_ALL, 16'hFFFF, CLASS_TOP,     1'b1, ST_EMPTY},
      '{CMD_DISMISS,   16'h0000, CLASS_TOP,     1'b1, ST_DISMISSED},
      '{CMD_ADD,       16'hFFFF, CLASS_UNKNOWN, 1'b1, ST_ADDED},
      '{CMD_ADD,       16'h0000, 3'd7,          1'b1, ST_ADDED},
      '{CMD_ADD,       16'h1234, CLASS_GUEST,   1'b0, ST_ADDED},
      '{CMD_ADD,       16'hA5A5, CLASS_TOP,     1'b0, ST_ADDED},
      '{CMD_ADD,       16'h5A5A, CLASS_MEMBER,  1'b0, ST_ADDED},
      '{CMD_ADD,       16'h0001, CLASS_HIGH,    1'b0, ST_ADDED},
      '{CMD_ADD,       16'h8000, CLASS_TOP,     1'b0, ST_ADDED},
      '{CMD_ADD,       16'h7FFF, 3'd5,          1'b0, ST_ADDED},
      '{CMD_ADD,       16'h00FF, CLASS_MEMBER,  1'b0, ST_ADDED},
      '{CMD_ADD,       16'hFF00, 3'd6,          1'b0, ST_ADDED},
      '{CMD_ADD,       16'h0F0F, CLASS_GUEST,   1'b0, ST_ADDED},
      '{CMD_ADD,       16'hF0F0, CLASS_HIGH,    1'b0, ST_ADDED},
      '{CMD_ADD,       16'h3C3C, CLASS_UNKNOWN, 1'b0, ST_ADDED},
      '{CMD_ADD,       16'hC3C3, CLASS_TOP,     1'b0, ST_ADDED},
      '{CMD_ADD,       16'h6666, CLASS_MEMBER,  1'b0, ST_ADDED},
      '{CMD_ADD,       16'h9999, CLASS_TOP,     1'b0, ST_ADDED},
      '{CMD_ADD,       16'hABCD, CLASS_HIGH,    1'b1, ST_FULL},
      '{CMD_SERVE_ONE, 16'h0000, CLASS_TOP,     1'b0, ST_SERVED},
      '{CMD_SERVE_ALL, 16'h0000, CLASS_TOP,     1'b0, ST_SERVED},
      '{CMD_ADD,       16'h4321, CLASS_MEMBER,  1'b0, ST_ADDED},
      '{CMD_DISMISS,   16'hFFFF, 3'd7,          1'b1, ST_DISMISSED},
      '{CMD_SERVE_ONE, 16'h0000, CLASS_TOP,     1'b1, ST_EMPTY}
    };

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_STEPS; i++) begin
      r.command     = directed_steps[i].command;
      r.request_tag = directed_steps[i].tag;
      r.class_code  = directed_steps[i].cls;
      send_command(r, directed_steps[i].typed, directed_steps[i].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sender_gaps = !(n >= 20 && n < 50);
      // drain everything once before carrying on
      if (n == 70) begin
        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
      end
      // lean on adds early so the queue fills and sorts deeply
      add_share = (n < 50) ? 78 : 50;
      pick = $urandom_range(99);
      if (pick < add_share)
        r.command = CMD_ADD;
      else if (pick < add_share + ((n < 50) ? 14 : 30))
        r.command = CMD_SERVE_ONE;
      else if (pick < add_share + ((n < 50) ? 18 : 42))
        r.command = CMD_SERVE_ALL;
      else
        r.command = CMD_DISMISS;
      r.request_tag = 16'($urandom_range(16'hFFFF));
      r.class_code  = CLASS_W'(($urandom_range(9) == 0) ? $urandom_range(7, 5)
                                                        : $urandom_range(4));
      send_command(r, 1'b0, ST_SERVED);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d commands (directed table and random), checked %0d results.",
             commands_sent, results_seen);
    $display("Queue-full rejects: %0d, serve-all drains: %0d, long receiver hold-off: %0d.",
             full_hits, drain_runs, held_once);
    if (errors == 0)
      $display("class_priority_queue_top verification clean");
    else
      $display("class_priority_queue_top verification failed");
    $finish;
  end

endmodule
